FILE: rtl/clamped_pi_regulator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the clamped PI regulator
// Shared property wrappers; every check is clocked on clk and off in reset.
// ---------------------------------------------------------------------------
`ifndef CLAMPED_PI_REGULATOR_MACROS_SVH
`define CLAMPED_PI_REGULATOR_MACROS_SVH

// Same-cycle implication.
`define CPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cpr_pkg.sv
// ---------------------------------------------------------------------------
// cpr_pkg
// Widths, reset values, register codes and the configuration bundle.
// ---------------------------------------------------------------------------
package cpr_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 16;
  localparam int INTEG_FRAC         = 16;

  localparam int IN_W    = 16;
  localparam int ERR_W   = 17;
  localparam int GAIN_W  = 18;
  localparam int LIM_W   = 16;
  localparam int INTEG_W = 34;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  localparam logic [GAIN_W-1:0]       PROP_GAIN_RST  = 18'd52429;
  localparam logic [GAIN_W-1:0]       INTEG_GAIN_RST = 18'd524;
  localparam logic signed [LIM_W-1:0] LIMIT_LOW_RST  = -16'sd460;
  localparam logic signed [LIM_W-1:0] LIMIT_HIGH_RST = 16'sd0;

  typedef enum logic [1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_LIMIT_LOW  = 2'd2,
    REG_LIMIT_HIGH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]       prop_gain;
    logic [GAIN_W-1:0]       integ_gain;
    logic signed [LIM_W-1:0] limit_low;
    logic signed [LIM_W-1:0] limit_high;
  } cfg_t;

endpackage

FILE: rtl/cpr_cfg.sv
// ---------------------------------------------------------------------------
// cpr_cfg
// APB register file holding gains and limits.
// ---------------------------------------------------------------------------
module cpr_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpr_pkg::ADDR_W-1:0]  paddr,
  input  logic [cpr_pkg::DATA_W-1:0]  pwdata,
  output logic [cpr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cpr_pkg::cfg_t               cfg
);

  logic                write_en;
  cpr_pkg::reg_idx_t   reg_idx;

  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite;
  assign reg_idx  = cpr_pkg::reg_idx_t'(paddr[cpr_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain  <= cpr_pkg::PROP_GAIN_RST;
      cfg.integ_gain <= cpr_pkg::INTEG_GAIN_RST;
      cfg.limit_low  <= cpr_pkg::LIMIT_LOW_RST;
      cfg.limit_high <= cpr_pkg::LIMIT_HIGH_RST;
    end else if (write_en) begin
      case (reg_idx)
        cpr_pkg::REG_PROP_GAIN:  cfg.prop_gain  <= pwdata[cpr_pkg::GAIN_W-1:0];
        cpr_pkg::REG_INTEG_GAIN: cfg.integ_gain <= pwdata[cpr_pkg::GAIN_W-1:0];
        cpr_pkg::REG_LIMIT_LOW:  cfg.limit_low  <= $signed(pwdata[cpr_pkg::LIM_W-1:0]);
        cpr_pkg::REG_LIMIT_HIGH: cfg.limit_high <= $signed(pwdata[cpr_pkg::LIM_W-1:0]);
        default: ;
      endcase
    end
  end

  // Gains read back zero-extended, limits sign-extended.
  always_comb begin
    case (reg_idx)
      cpr_pkg::REG_PROP_GAIN:  prdata = cpr_pkg::DATA_W'(cfg.prop_gain);
      cpr_pkg::REG_INTEG_GAIN: prdata = cpr_pkg::DATA_W'(cfg.integ_gain);
      cpr_pkg::REG_LIMIT_LOW:  prdata = cpr_pkg::DATA_W'(cfg.limit_low);
      cpr_pkg::REG_LIMIT_HIGH: prdata = cpr_pkg::DATA_W'(cfg.limit_high);
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: rtl/cpr_calc.sv
// ---------------------------------------------------------------------------
// cpr_calc
// One-pass PI arithmetic: error, integrator update with clamp, drive.
// ---------------------------------------------------------------------------
module cpr_calc #(
  parameter int GAIN_FRAC_BITS = cpr_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic signed [cpr_pkg::IN_W-1:0]    reference,
  input  logic signed [cpr_pkg::IN_W-1:0]    measured,
  input  logic signed [cpr_pkg::ERR_W-1:0]   prev_error,
  input  logic signed [cpr_pkg::INTEG_W-1:0] integrator,
  input  cpr_pkg::cfg_t                      cfg,
  output logic signed [cpr_pkg::ERR_W-1:0]   err,
  output logic signed [cpr_pkg::INTEG_W-1:0] integ_next,
  output logic signed [cpr_pkg::LIM_W-1:0]   drive
);

  localparam int IF      = cpr_pkg::INTEG_FRAC;
  localparam int GF      = GAIN_FRAC_BITS;
  localparam int UP_INC  = (GF < IF) ? IF - GF : 0;
  localparam int DN_INC  = (GF > IF) ? GF - IF : 0;
  localparam int ESUM_W  = cpr_pkg::ERR_W + 1;
  localparam int INCR_W  = ESUM_W + cpr_pkg::GAIN_W;
  localparam int INC_W   = INCR_W + UP_INC;
  localparam int SUM_W   = ((INC_W > cpr_pkg::INTEG_W) ? INC_W : cpr_pkg::INTEG_W) + 1;
  localparam int PROP_W  = cpr_pkg::ERR_W + cpr_pkg::GAIN_W;
  localparam int TF      = (GF > IF) ? GF : IF;
  localparam int P_UP    = TF - GF;
  localparam int I_UP    = TF - IF;
  localparam int PW      = PROP_W + P_UP;
  localparam int IW      = cpr_pkg::INTEG_W + I_UP;
  localparam int TOT_W   = ((PW > IW) ? PW : IW) + 1;
  localparam int QW      = TOT_W - TF;
  localparam logic [TOT_W-1:0] BIAS = TOT_W'((65'd1 << TF) - 65'd1);

  logic signed [ESUM_W-1:0] err_sum;
  logic signed [INCR_W-1:0] inc_raw;
  logic signed [INC_W-1:0]  inc;
  logic signed [SUM_W-1:0]  isum;
  logic signed [SUM_W-1:0]  ilo;
  logic signed [SUM_W-1:0]  ihi;
  logic signed [SUM_W-1:0]  iclamp;
  logic signed [PROP_W-1:0] prop;
  logic signed [TOT_W-1:0]  total;
  logic signed [TOT_W-1:0]  total_adj;
  logic signed [TOT_W-1:0]  quot;
  logic signed [QW-1:0]     whole;
  logic signed [QW-1:0]     qlo;
  logic signed [QW-1:0]     qhi;
  logic signed [QW-1:0]     qclamp;

  always_comb begin
    err     = cpr_pkg::ERR_W'(reference) - cpr_pkg::ERR_W'(measured);
    err_sum = ESUM_W'(err) + ESUM_W'(prev_error);

    // Trapezoid step, moved to the integrator's fraction (floor on right shift).
    inc_raw = INCR_W'(err_sum) * INCR_W'($signed({1'b0, cfg.integ_gain}));
    inc     = (INC_W'(inc_raw) <<< UP_INC) >>> DN_INC;

    isum = SUM_W'(integrator) + SUM_W'(inc);
    ilo  = SUM_W'(cfg.limit_low) <<< IF;
    ihi  = SUM_W'(cfg.limit_high) <<< IF;
    if (isum > ihi) begin
      iclamp = ihi;
    end else if (isum < ilo) begin
      iclamp = ilo;
    end else begin
      iclamp = isum;
    end
    integ_next = $signed(iclamp[cpr_pkg::INTEG_W-1:0]);

    // Output sum at the wider fraction, then truncate toward zero.
    prop  = PROP_W'(err) * PROP_W'($signed({1'b0, cfg.prop_gain}));
    total = (TOT_W'(prop) <<< P_UP) + (TOT_W'(integ_next) <<< I_UP);
    total_adj = total[TOT_W-1] ? total + $signed(BIAS) : total;
    quot  = total_adj >>> TF;
    whole = $signed(quot[QW-1:0]);

    qlo = QW'(cfg.limit_low);
    qhi = QW'(cfg.limit_high);
    if (whole > qhi) begin
      qclamp = qhi;
    end else if (whole < qlo) begin
      qclamp = qlo;
    end else begin
      qclamp = whole;
    end
    drive = $signed(qclamp[cpr_pkg::LIM_W-1:0]);
  end

endmodule

FILE: rtl/clamped_pi_regulator.sv
// ---------------------------------------------------------------------------
// clamped_pi_regulator
// PI regulator with a trapezoidal integrator clamped to programmable limits.
// ---------------------------------------------------------------------------
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------
//  input    in_valid / in_stall  reference, measured
//  output   out_valid/ out_stall drive
//  config   APB write / read     prop_gain, integ_gain, limit_low, limit_high
//
//  From acceptance an item waits in the input register, then passes through
//  the PI arithmetic into the result register.
//  One item per cycle is sustained while out_stall is low; the integrator
//  feedback loop (multiply, add, clamp) closes through the integrator register.
//  Reset clears the integrator, the previous error and both valid flags and
//  restores the default gains and limits.
//  A stall on the output holds the result and raises in_stall once the
//  input register is full, so an empty input register takes one more item.
// ---------------------------------------------------------------------------
`include "clamped_pi_regulator_macros.svh"

module clamped_pi_regulator #(
  parameter int GAIN_FRAC_BITS = cpr_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [cpr_pkg::IN_W-1:0]   reference,
  input  logic signed [cpr_pkg::IN_W-1:0]   measured,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cpr_pkg::LIM_W-1:0]  drive,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cpr_pkg::ADDR_W-1:0]        paddr,
  input  logic [cpr_pkg::DATA_W-1:0]        pwdata,
  output logic [cpr_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  cpr_pkg::cfg_t                      cfg;

  // Input register.
  logic                               held_valid;
  logic signed [cpr_pkg::IN_W-1:0]    held_reference;
  logic signed [cpr_pkg::IN_W-1:0]    held_measured;

  // Controller state.
  logic signed [cpr_pkg::INTEG_W-1:0] integrator;
  logic signed [cpr_pkg::ERR_W-1:0]   prev_error;

  logic signed [cpr_pkg::ERR_W-1:0]   err;
  logic signed [cpr_pkg::INTEG_W-1:0] integ_next;
  logic signed [cpr_pkg::LIM_W-1:0]   drive_next;

  logic                               out_free;
  logic                               load;
  logic                               accept;
  logic                               limits_ordered;

  // Limits moved to the integrator's fraction, for the checks below.
  logic signed [cpr_pkg::INTEG_W-1:0] integ_lo_fx;
  logic signed [cpr_pkg::INTEG_W-1:0] integ_hi_fx;
  logic                               integ_in_lim;
  logic                               drive_in_lim;

  cpr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpr_calc #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_calc (
    .reference  (held_reference),
    .measured   (held_measured),
    .prev_error (prev_error),
    .integrator (integrator),
    .cfg        (cfg),
    .err        (err),
    .integ_next (integ_next),
    .drive      (drive_next)
  );

  // The result register frees up when empty or when its item is taken.
  assign out_free = !out_valid || !out_stall;
  // Move the held item through the arithmetic into the result register.
  assign load     = held_valid && out_free;
  // Stall input only while the held item cannot move on.
  assign in_stall = held_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (load) begin
      held_valid <= 1'b0;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_reference <= reference;
      held_measured  <= measured;
    end
  end

  // Advance controller state once per item, as it leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      prev_error <= '0;
    end else if (load) begin
      integrator <= integ_next;
      prev_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive <= drive_next;
    end
  end

  assign limits_ordered = cfg.limit_low <= cfg.limit_high;

  assign integ_lo_fx =
    cpr_pkg::INTEG_W'($signed({cfg.limit_low, {cpr_pkg::INTEG_FRAC{1'b0}}}));
  assign integ_hi_fx =
    cpr_pkg::INTEG_W'($signed({cfg.limit_high, {cpr_pkg::INTEG_FRAC{1'b0}}}));
  assign integ_in_lim = (integ_next >= integ_lo_fx) && (integ_next <= integ_hi_fx);
  assign drive_in_lim = (drive >= cfg.limit_low) && (drive <= cfg.limit_high);

  `CPR_ASSERT_NOW(a_integ_in_limits, load && limits_ordered, integ_in_lim, "integ out of limits")
  `CPR_ASSERT_NOW(a_drive_in_limits, out_valid && limits_ordered, drive_in_lim, "drive out of limits")
  `CPR_ASSERT_NEXT(a_load_valid, load, out_valid, "result not raised after load")
  `CPR_ASSERT_NEXT(a_err_kept, load, prev_error == $past(err), "prev error not advanced")
  `CPR_ASSERT_NEXT(a_integ_kept, load, integrator == $past(integ_next), "integ not advanced")

endmodule
